@@ rtl/bddq_pkg.sv @@
// Shared constants and types for the bounded deque with odd filter.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package bddq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int REM_W = 6;

    // input modes
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_LIST_FWD   = 3'd2;
    localparam logic [2:0] MODE_LIST_BWD   = 3'd3;
    localparam logic [2:0] MODE_DROP_ODD   = 3'd4;
    localparam logic [2:0] MODE_CLEAR      = 3'd5;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // chain operations, broadcast to all cells
    typedef logic [2:0] chain_op_t;
    localparam chain_op_t OP_HOLD       = 3'd0;
    localparam chain_op_t OP_PUSH_FRONT = 3'd1;
    localparam chain_op_t OP_PUSH_BACK  = 3'd2;
    localparam chain_op_t OP_ROT_FWD    = 3'd3;
    localparam chain_op_t OP_ROT_BWD    = 3'd4;
    localparam chain_op_t OP_DROP_FRONT = 3'd5;

    // per-cell source select
    typedef logic [2:0] cell_sel_t;
    localparam cell_sel_t SEL_HOLD  = 3'd0;
    localparam cell_sel_t SEL_LEFT  = 3'd1;
    localparam cell_sel_t SEL_RIGHT = 3'd2;
    localparam cell_sel_t SEL_FRONT = 3'd3;
    localparam cell_sel_t SEL_BACK  = 3'd4;
    localparam cell_sel_t SEL_LOAD  = 3'd5;

    typedef struct packed {
        chain_op_t               op;
        logic [CNT_W-1:0]        len;
        logic signed [VAL_W-1:0] value;
    } chain_cmd_t;

endpackage

@@ rtl/bounded_deque_with_odd_filter.sv @@
// Top level of the bounded deque with odd filter: sequencer and result register.
// Depends on bddq_pkg and bddq_chain (which uses bddq_cell).
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Word
// command   in         start & !busy            mode, item_value
// result    out        strobe (one cycle each)  out_value, status, remaining, last
//
// Push, clear, remove-odd on an empty queue and listing of an empty queue give
// their result the cycle after start. A listing of n entries keeps busy high
// and emits one word per cycle, set by the chain rotating one cell per cycle.
// Remove-odd on n entries takes one chain step per entry. Modes 6 and 7 are
// taken and ignored.
// Reset (rst_n low, asynchronous) empties the queue; cell contents are not
// cleared. The receiver cannot stall: every strobe is a delivered word.

module bounded_deque_with_odd_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        mode,
    input  logic signed [bddq_pkg::VAL_W-1:0] item_value,
    output logic                              strobe,
    output logic signed [bddq_pkg::VAL_W-1:0] out_value,
    output logic [1:0]                        status,
    output logic [bddq_pkg::REM_W-1:0]        remaining,
    output logic                              last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LIST_F = 2'd1;
    localparam logic [1:0] S_LIST_B = 2'd2;
    localparam logic [1:0] S_ODD    = 2'd3;

    localparam logic [bddq_pkg::CNT_W-1:0] FULL_CNT = bddq_pkg::CNT_W'(bddq_pkg::DEPTH);

    logic [1:0]                 state_reg, state_next;
    logic [bddq_pkg::CNT_W-1:0] fill_reg,  fill_next;
    logic [bddq_pkg::CNT_W-1:0] steps_reg, steps_next;   // entries left to visit
    logic [bddq_pkg::CNT_W-1:0] len_reg,   len_next;     // live region in remove-odd

    logic                              strobe_reg, strobe_next;
    logic signed [bddq_pkg::VAL_W-1:0] value_reg,  value_next;
    logic [1:0]                        status_reg, status_next;
    logic [bddq_pkg::CNT_W-1:0]        rem_reg,    rem_next;
    logic                              last_reg,   last_next;

    bddq_pkg::chain_cmd_t              cmd;
    logic signed [bddq_pkg::VAL_W-1:0] front_val;
    logic signed [bddq_pkg::VAL_W-1:0] back_val;
    logic                              front_odd;
    logic [bddq_pkg::CNT_W-1:0]        len_after;
    logic                              final_step;

    bddq_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .front_val (front_val),
        .back_val  (back_val)
    );

    assign front_odd  = front_val[0];
    assign len_after  = front_odd ? (len_reg - bddq_pkg::CNT_W'(1)) : len_reg;
    assign final_step = (steps_reg == bddq_pkg::CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        steps_next  = steps_reg;
        len_next    = len_reg;
        strobe_next = 1'b0;
        value_next  = '0;
        status_next = bddq_pkg::ST_OK;
        rem_next    = fill_reg;
        last_next   = 1'b1;
        cmd.op      = bddq_pkg::OP_HOLD;
        cmd.len     = fill_reg;
        cmd.value   = item_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        bddq_pkg::MODE_PUSH_FRONT,
                        bddq_pkg::MODE_PUSH_BACK:
                        begin
                            strobe_next = 1'b1;
                            if (fill_reg == FULL_CNT)
                            begin
                                status_next = bddq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op    = (mode == bddq_pkg::MODE_PUSH_FRONT) ?
                                            bddq_pkg::OP_PUSH_FRONT :
                                            bddq_pkg::OP_PUSH_BACK;
                                fill_next = fill_reg + bddq_pkg::CNT_W'(1);
                                rem_next  = fill_reg + bddq_pkg::CNT_W'(1);
                            end
                        end
                        bddq_pkg::MODE_LIST_FWD,
                        bddq_pkg::MODE_LIST_BWD:
                        begin
                            if (fill_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = bddq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                steps_next = fill_reg;
                                state_next = (mode == bddq_pkg::MODE_LIST_FWD) ?
                                             S_LIST_F : S_LIST_B;
                            end
                        end
                        bddq_pkg::MODE_DROP_ODD:
                        begin
                            if (fill_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = bddq_pkg::ST_DONE;
                            end
                            else
                            begin
                                steps_next = fill_reg;
                                len_next   = fill_reg;
                                state_next = S_ODD;
                            end
                        end
                        bddq_pkg::MODE_CLEAR:
                        begin
                            strobe_next = 1'b1;
                            status_next = bddq_pkg::ST_DONE;
                            fill_next   = '0;
                            rem_next    = '0;
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST_F,
            S_LIST_B:
            begin
                // emit the end word, then rotate it to the other end of the region
                strobe_next = 1'b1;
                value_next  = (state_reg == S_LIST_F) ? front_val : back_val;
                last_next   = final_step;
                cmd.op      = (state_reg == S_LIST_F) ? bddq_pkg::OP_ROT_FWD :
                                                        bddq_pkg::OP_ROT_BWD;
                steps_next  = steps_reg - bddq_pkg::CNT_W'(1);
                if (final_step)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ODD:
            begin
                // front word goes to the back if even, is dropped if odd
                cmd.len    = len_reg;
                cmd.op     = front_odd ? bddq_pkg::OP_DROP_FRONT : bddq_pkg::OP_ROT_FWD;
                len_next   = len_after;
                steps_next = steps_reg - bddq_pkg::CNT_W'(1);
                if (final_step)
                begin
                    fill_next   = len_after;
                    strobe_next = 1'b1;
                    status_next = bddq_pkg::ST_DONE;
                    rem_next    = len_after;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            steps_reg  <= '0;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            steps_reg  <= steps_next;
            len_reg    <= len_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign out_value = value_reg;
    assign status    = status_reg;
    assign remaining = bddq_pkg::REM_W'(rem_reg);
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count above depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == bddq_pkg::ST_FULL) |-> (rem_reg == FULL_CNT))
        else $error("full status with queue not full");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == bddq_pkg::ST_EMPTY) |-> (rem_reg == '0 && last))
        else $error("empty status inconsistent");

    a_list_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST_F || state_reg == S_LIST_B) |=> strobe)
        else $error("listing cycle without a word");

    a_odd_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ODD) |-> (len_reg <= fill_reg))
        else $error("remove-odd region grew");
`endif

endmodule

@@ rtl/bddq_cell.sv @@
// One storage cell of the deque chain: a word register with a source mux.
// Depends on bddq_pkg.
`timescale 1ns / 1ps

module bddq_cell (
    input  logic                              clk,
    input  bddq_pkg::cell_sel_t               sel,
    input  logic signed [bddq_pkg::VAL_W-1:0] left_in,
    input  logic signed [bddq_pkg::VAL_W-1:0] right_in,
    input  logic signed [bddq_pkg::VAL_W-1:0] front_in,
    input  logic signed [bddq_pkg::VAL_W-1:0] back_in,
    input  logic signed [bddq_pkg::VAL_W-1:0] load_in,
    output logic signed [bddq_pkg::VAL_W-1:0] q
);

    logic signed [bddq_pkg::VAL_W-1:0] q_reg;
    logic signed [bddq_pkg::VAL_W-1:0] q_next;

    always_comb
    begin
        unique case (sel)
            bddq_pkg::SEL_LEFT:  q_next = left_in;
            bddq_pkg::SEL_RIGHT: q_next = right_in;
            bddq_pkg::SEL_FRONT: q_next = front_in;
            bddq_pkg::SEL_BACK:  q_next = back_in;
            bddq_pkg::SEL_LOAD:  q_next = load_in;
            default:             q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/bddq_chain.sv @@
// Row of DEPTH cells holding the deque in logical order (cell 0 = front).
// Depends on bddq_pkg and bddq_cell.
`timescale 1ns / 1ps

module bddq_chain (
    input  logic                              clk,
    input  bddq_pkg::chain_cmd_t              cmd,
    output logic signed [bddq_pkg::VAL_W-1:0] front_val,
    output logic signed [bddq_pkg::VAL_W-1:0] back_val
);

    logic signed [bddq_pkg::VAL_W-1:0] q [bddq_pkg::DEPTH];
    logic [bddq_pkg::CNT_W-1:0]        len_m1;
    logic [bddq_pkg::IDX_W-1:0]        back_idx;

    assign len_m1    = cmd.len - bddq_pkg::CNT_W'(1);
    assign back_idx  = len_m1[bddq_pkg::IDX_W-1:0];
    assign front_val = q[0];
    assign back_val  = q[back_idx];

    for (genvar i = 0; i < bddq_pkg::DEPTH; i++)
    begin : g_cell
        bddq_pkg::cell_sel_t               sel;
        logic signed [bddq_pkg::VAL_W-1:0] left_in;
        logic signed [bddq_pkg::VAL_W-1:0] right_in;
        logic                              below_tail;
        logic                              at_tail;
        logic                              in_region;
        logic                              at_len;

        if (i == 0)
        begin : g_first
            assign left_in = q[i];
        end
        else
        begin : g_mid
            assign left_in = q[i-1];
        end

        if (i == bddq_pkg::DEPTH - 1)
        begin : g_last
            assign right_in = q[i];
        end
        else
        begin : g_inner
            assign right_in = q[i+1];
        end

        assign at_len     = (bddq_pkg::CNT_W'(i) == cmd.len);
        assign in_region  = (bddq_pkg::CNT_W'(i) < cmd.len);
        assign at_tail    = in_region && (bddq_pkg::CNT_W'(i) == len_m1);
        assign below_tail = in_region && !at_tail;

        always_comb
        begin
            sel = bddq_pkg::SEL_HOLD;
            unique case (cmd.op)
                bddq_pkg::OP_PUSH_FRONT:
                    sel = (i == 0) ? bddq_pkg::SEL_LOAD : bddq_pkg::SEL_LEFT;
                bddq_pkg::OP_PUSH_BACK:
                    if (at_len) sel = bddq_pkg::SEL_LOAD;
                bddq_pkg::OP_ROT_FWD:
                begin
                    if (below_tail)   sel = bddq_pkg::SEL_RIGHT;
                    else if (at_tail) sel = bddq_pkg::SEL_FRONT;
                end
                bddq_pkg::OP_DROP_FRONT:
                    if (below_tail) sel = bddq_pkg::SEL_RIGHT;
                bddq_pkg::OP_ROT_BWD:
                begin
                    if (i == 0)         sel = bddq_pkg::SEL_BACK;
                    else if (in_region) sel = bddq_pkg::SEL_LEFT;
                end
                default:
                    sel = bddq_pkg::SEL_HOLD;
            endcase
        end

        bddq_cell u_cell (
            .clk      (clk),
            .sel      (sel),
            .left_in  (left_in),
            .right_in (right_in),
            .front_in (front_val),
            .back_in  (back_val),
            .load_in  (cmd.value),
            .q        (q[i])
        );
    end

endmodule
